FILE: hw/rtl/tlik_pkg.sv
// Shared widths, constants and types for the two-link arm inverse kinematics block.
package tlik_pkg;

  // Field widths
  localparam int unsigned CoordW = 15;
  localparam int unsigned LenW   = 14;
  localparam int unsigned ShW    = 15;
  localparam int unsigned ElW    = 14;

  // Internal widths
  localparam int unsigned SqW    = 29;   // x^2, l1*l2*2 and friends
  localparam int unsigned NumW   = 31;   // signed numerator of the elbow cosine
  localparam int unsigned DenW   = 29;   // 2*l1*l2
  localparam int unsigned DiffW  = 58;   // den^2 - num^2
  localparam int unsigned RootW  = 29;   // isqrt of the above
  localparam int unsigned RemW   = 32;   // sqrt partial remainder
  localparam int unsigned P2W    = 43;   // l2 * root
  localparam int unsigned Q2W    = 45;   // l1*den + l2*num, signed
  localparam int unsigned VecW   = 44;   // vector component into the angle lanes
  localparam int unsigned MsbW   = 6;    // bit index into a VecW word
  localparam int unsigned CorW   = 34;   // CORDIC x/y datapath, signed
  localparam int unsigned ZW     = 19;   // angle, radians * 65536, signed
  localparam int unsigned NormTop = 29;  // larger component lands in [2^29, 2^30)

  // Latencies
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtLat     = RootW;
  localparam int unsigned LaneLat     = CordicSteps + 3;

  // Angle constants, radians * 65536 and radians * 4096
  localparam logic signed [ZW-1:0] HalfPiQ16 = 19'sd102944;
  localparam logic signed [ZW:0]   PiQ16     = 20'sd205887;
  localparam int                   OutPi     = 12868;

  // Configuration register indexes
  localparam logic CfgUpperArm = 1'b0;
  localparam logic CfgForearm  = 1'b1;

  // Reset values of the link lengths
  localparam logic [LenW-1:0] ResetUpper = 14'd9088;
  localparam logic [LenW-1:0] ResetFore  = 14'd6400;

  // Side data that rides along with the square-root pipeline
  typedef struct packed {
    logic                   unreach;
    logic                   neg;
    logic [DenW-1:0]        anum;
    logic [DenW-1:0]        den;
    logic signed [NumW-1:0] num;
    logic [LenW-1:0]        l1;
    logic [LenW-1:0]        l2;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } tlik_side_t;

  // Flags that ride along with the angle lanes
  typedef struct packed {
    logic unreach;
    logic neg;
    logic x_zero;
    logic y_zero;
    logic y_neg;
    logic a_flip;
    logic q2_zero;
    logic q2_neg;
    logic p2_zero;
  } tlik_flag_t;

  // Arctangent of 2^-i, radians * 65536
  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:    r = 19'sd51472;
      4'd1:    r = 19'sd30386;
      4'd2:    r = 19'sd16055;
      4'd3:    r = 19'sd8150;
      4'd4:    r = 19'sd4091;
      4'd5:    r = 19'sd2047;
      4'd6:    r = 19'sd1024;
      4'd7:    r = 19'sd512;
      4'd8:    r = 19'sd256;
      4'd9:    r = 19'sd128;
      4'd10:   r = 19'sd64;
      4'd11:   r = 19'sd32;
      4'd12:   r = 19'sd16;
      4'd13:   r = 19'sd8;
      4'd14:   r = 19'sd4;
      default: r = 19'sd2;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/tlik_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module tlik_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tlik_pkg::DiffW-1:0] val_i,
  output logic [tlik_pkg::RootW-1:0] root_o
);
  import tlik_pkg::*;

  logic [RemW-1:0]  rem_q  [SqrtLat];
  logic [RootW-1:0] root_q [SqrtLat];
  logic [DiffW-1:0] val_q  [SqrtLat];

  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [DiffW-1:0] val_in;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  t;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
    end

    // Bring down two bits, try root*4+1
    always_comb begin
      t     = {rem_in[RemW-3:0], val_in[DiffW-1:DiffW-2]};
      trial = {1'b0, root_in, 2'b01};
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (t - trial) : t;
        root_q[k] <= {root_in[RootW-2:0], ge};
        val_q[k]  <= {val_in[DiffW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SqrtLat-1];

endmodule

FILE: hw/rtl/tlik_vec_angle.sv
// Angle of a first-quadrant vector: normalize, then a 16-step CORDIC in vectoring mode.
module tlik_vec_angle (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tlik_pkg::VecW-1:0]     a_i,
  input  logic [tlik_pkg::VecW-1:0]     b_i,
  output logic signed [tlik_pkg::ZW-1:0] z_o
);
  import tlik_pkg::*;

  // Stage one: find the leading one of a|b
  logic [VecW-1:0] a1_q, b1_q;
  logic [MsbW-1:0] msb1_q;
  logic            az1_q, bz1_q;
  logic [VecW-1:0] both;
  logic [MsbW-1:0] msb_d;

  always_comb begin
    both  = a_i | b_i;
    msb_d = '0;
    for (int j = 0; j < VecW; j++) begin
      if (both[j]) msb_d = MsbW'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a_i;
      b1_q   <= b_i;
      msb1_q <= msb_d;
      az1_q  <= (a_i == '0);
      bz1_q  <= (b_i == '0);
    end
  end

  // Stage two: shift so the larger component lies in [2^29, 2^30)
  logic signed [CorW-1:0] x2_q, y2_q;
  logic                   az2_q, bz2_q;
  logic [VecW-1:0]        a_sh, b_sh;
  logic [MsbW-1:0]        amt;

  always_comb begin
    if (msb1_q >= MsbW'(NormTop)) begin
      amt  = msb1_q - MsbW'(NormTop);
      a_sh = a1_q >> amt;
      b_sh = b1_q >> amt;
    end else begin
      amt  = MsbW'(NormTop) - msb1_q;
      a_sh = a1_q << amt;
      b_sh = b1_q << amt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q  <= $signed({{(CorW-NormTop-1){1'b0}}, a_sh[NormTop:0]});
      y2_q  <= $signed({{(CorW-NormTop-1){1'b0}}, b_sh[NormTop:0]});
      az2_q <= az1_q;
      bz2_q <= bz1_q;
    end
  end

  // CORDIC rotations, one per stage
  logic signed [CorW-1:0] x_q [CordicSteps];
  logic signed [CorW-1:0] y_q [CordicSteps];
  logic signed [ZW-1:0]   z_q [CordicSteps];
  logic                   az_q [CordicSteps];
  logic                   bz_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    logic signed [CorW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0]   z_in;
    logic                   az_in, bz_in;

    if (i == 0) begin : g_first
      assign x_in  = x2_q;
      assign y_in  = y2_q;
      assign z_in  = '0;
      assign az_in = az2_q;
      assign bz_in = bz2_q;
    end else begin : g_next
      assign x_in  = x_q[i-1];
      assign y_in  = y_q[i-1];
      assign z_in  = z_q[i-1];
      assign az_in = az_q[i-1];
      assign bz_in = bz_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[CorW-1]) begin
          x_q[i] <= x_in + ys;
          y_q[i] <= y_in - xs;
          z_q[i] <= z_in + atan_q16(4'(i));
        end else begin
          x_q[i] <= x_in - ys;
          y_q[i] <= y_in + xs;
          z_q[i] <= z_in - atan_q16(4'(i));
        end
        az_q[i] <= az_in;
        bz_q[i] <= bz_in;
      end
    end
  end

  // Pick the special cases: flat vector is zero, vertical one is pi/2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (bz_q[CordicSteps-1]) begin
        z_o <= '0;
      end else if (az_q[CordicSteps-1]) begin
        z_o <= HalfPiQ16;
      end else begin
        z_o <= z_q[CordicSteps-1];
      end
    end
  end

endmodule

FILE: hw/rtl/two_link_arm_inverse_kinematics_top.sv
// Pipeline from item acceptance to result valid: input register, 4 front stages, 29 sqrt
// stages, 2 stages after the root, 19 angle-lane stages, output register.
// Throughput: one item per cycle; the whole pipeline holds while the output item waits.
// The square-root pipeline (one bit per stage) and the 16-step CORDIC lanes set the depth.
// Reset: pipeline valids clear, link lengths return to 35.5 cm and 25 cm.
// Top level of the two-link planar arm inverse kinematics pipeline.
module two_link_arm_inverse_kinematics_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [tlik_pkg::LenW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tlik_pkg::CoordW-1:0] target_x_i,
  input  logic signed [tlik_pkg::CoordW-1:0] target_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tlik_pkg::ShW-1:0]   shoulder_angle_o,
  output logic [tlik_pkg::ElW-1:0]          elbow_angle_o,
  output logic                              unreachable_o
);
  import tlik_pkg::*;

  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // Link length registers
  logic [LenW-1:0] l1_q, l2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= ResetUpper;
      l2_q <= ResetFore;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUpperArm: l1_q <= cfg_wdata_i;
        CfgForearm:  l2_q <= cfg_wdata_i;
        default:     l1_q <= l1_q;
      endcase
    end
  end

  // Valid bits of the pipeline stages
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic vs_q [SqrtLat];
  logic vl_q [LaneLat];

  // Stage 0: capture the item with the current link lengths
  logic signed [CoordW-1:0] x0_q, y0_q;
  logic [LenW-1:0]          l1_0_q, l2_0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q   <= target_x_i;
      y0_q   <= target_y_i;
      l1_0_q <= l1_q;
      l2_0_q <= l2_q;
    end
  end

  // Stage 1: squares and the link product
  logic signed [2*CoordW-1:0] xx_p, yy_p;
  logic [SqW-1:0]             xx1_q, yy1_q;
  logic [2*LenW-1:0]          ll1_1_q, ll2_1_q, l12_1_q;
  logic signed [CoordW-1:0]   x1_q, y1_q;
  logic [LenW-1:0]            l1_1_q, l2_1_q;
  assign xx_p = x0_q * x0_q;
  assign yy_p = y0_q * y0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xx1_q   <= xx_p[SqW-1:0];
      yy1_q   <= yy_p[SqW-1:0];
      ll1_1_q <= l1_0_q * l1_0_q;
      ll2_1_q <= l2_0_q * l2_0_q;
      l12_1_q <= l1_0_q * l2_0_q;
      x1_q    <= x0_q;
      y1_q    <= y0_q;
      l1_1_q  <= l1_0_q;
      l2_1_q  <= l2_0_q;
    end
  end

  // Stage 2: numerator and denominator of the elbow cosine
  logic signed [NumW-1:0]   num2_q;
  logic [DenW-1:0]          den2_q;
  logic signed [CoordW-1:0] x2_q, y2_q;
  logic [LenW-1:0]          l1_2_q, l2_2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      num2_q <= $signed(NumW'(xx1_q) + NumW'(yy1_q) - NumW'(ll1_1_q) - NumW'(ll2_1_q));
      den2_q <= {l12_1_q, 1'b0};
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      l1_2_q <= l1_1_q;
      l2_2_q <= l2_1_q;
    end
  end

  // Stage 3: reach test and the two squares under the root
  logic [NumW-1:0]  anum_full;
  logic [DenW-1:0]  anum3;
  logic [DiffW-1:0] dd3_q, nn3_q;
  tlik_side_t       sb3_q;
  assign anum_full = num2_q[NumW-1] ? NumW'(-num2_q) : NumW'(num2_q);
  assign anum3     = anum_full[DenW-1:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dd3_q         <= den2_q * den2_q;
      nn3_q         <= anum3 * anum3;
      sb3_q.unreach <= (den2_q == '0) || (anum_full > NumW'(den2_q));
      sb3_q.neg     <= num2_q[NumW-1];
      sb3_q.anum    <= anum3;
      sb3_q.den     <= den2_q;
      sb3_q.num     <= num2_q;
      sb3_q.l1      <= l1_2_q;
      sb3_q.l2      <= l2_2_q;
      sb3_q.x       <= x2_q;
      sb3_q.y       <= y2_q;
    end
  end

  // Stage 4: radicand
  logic [DiffW-1:0] diff4_q;
  tlik_side_t       sb4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      diff4_q <= dd3_q - nn3_q;
      sb4_q   <= sb3_q;
    end
  end

  // Square root, side data delayed alongside
  logic [RootW-1:0] root;
  tlik_side_t       sbs_q [SqrtLat];

  tlik_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (diff4_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sbs_q[0] <= sb4_q;
      for (int k = 1; k < SqrtLat; k++) begin
        sbs_q[k] <= sbs_q[k-1];
      end
    end
  end

  // Stage 5: numerator and denominator of the shoulder correction
  tlik_side_t              sbe;
  logic [P2W-1:0]          p2_5_q;
  logic signed [Q2W-1:0]   q2_5_q;
  logic [RootW-1:0]        root5_q;
  tlik_side_t              sb5_q;
  logic [P2W-1:0]          prod1;
  logic signed [Q2W:0]     prod2;
  assign sbe   = sbs_q[SqrtLat-1];
  assign prod1 = sbe.l1 * sbe.den;
  assign prod2 = $signed({1'b0, sbe.l2}) * sbe.num;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_5_q  <= sbe.l2 * root;
      q2_5_q  <= $signed({2'b00, prod1}) + $signed(prod2[Q2W-1:0]);
      root5_q <= root;
      sb5_q   <= sbe;
    end
  end

  // Stage 6: lane inputs as magnitudes, sign flags aside
  logic [VecW-1:0] ae_q, be_q, as_q, bs_q, aa_q, ba_q;
  tlik_flag_t      fl6_q;
  logic [Q2W-1:0]  q2_abs;
  logic [CoordW:0] x_abs, y_abs;
  assign q2_abs = q2_5_q[Q2W-1] ? Q2W'(-q2_5_q) : Q2W'(q2_5_q);
  assign x_abs  = sb5_q.x[CoordW-1] ? -{sb5_q.x[CoordW-1], sb5_q.x}
                                    :  {sb5_q.x[CoordW-1], sb5_q.x};
  assign y_abs  = sb5_q.y[CoordW-1] ? -{sb5_q.y[CoordW-1], sb5_q.y}
                                    :  {sb5_q.y[CoordW-1], sb5_q.y};
  always_ff @(posedge clk_i) begin
    if (en) begin
      ae_q          <= VecW'(sb5_q.anum);
      be_q          <= VecW'(root5_q);
      as_q          <= q2_abs[VecW-1:0];
      bs_q          <= VecW'(p2_5_q);
      aa_q          <= VecW'(x_abs);
      ba_q          <= VecW'(y_abs);
      fl6_q.unreach <= sb5_q.unreach;
      fl6_q.neg     <= sb5_q.neg;
      fl6_q.x_zero  <= (sb5_q.x == '0);
      fl6_q.y_zero  <= (sb5_q.y == '0);
      fl6_q.y_neg   <= sb5_q.y[CoordW-1];
      fl6_q.a_flip  <= sb5_q.x[CoordW-1] != sb5_q.y[CoordW-1];
      fl6_q.q2_zero <= (q2_5_q == '0);
      fl6_q.q2_neg  <= q2_5_q[Q2W-1];
      fl6_q.p2_zero <= (p2_5_q == '0);
    end
  end

  // Three angle lanes: elbow, target direction, shoulder correction
  logic signed [ZW-1:0] ze, za, zs;
  tlik_flag_t           fl_q [LaneLat];

  tlik_vec_angle u_lane_elbow (
    .clk_i (clk_i), .en_i (en), .a_i (ae_q), .b_i (be_q), .z_o (ze)
  );
  tlik_vec_angle u_lane_target (
    .clk_i (clk_i), .en_i (en), .a_i (aa_q), .b_i (ba_q), .z_o (za)
  );
  tlik_vec_angle u_lane_corr (
    .clk_i (clk_i), .en_i (en), .a_i (as_q), .b_i (bs_q), .z_o (zs)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fl6_q;
      for (int k = 1; k < LaneLat; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // Valid chain through every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int k = 0; k < SqrtLat; k++) vs_q[k] <= 1'b0;
      for (int k = 0; k < LaneLat; k++) vl_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vs_q[0] <= v4_q;
      for (int k = 1; k < SqrtLat; k++) vs_q[k] <= vs_q[k-1];
      v5_q    <= vs_q[SqrtLat-1];
      v6_q    <= v5_q;
      vl_q[0] <= v6_q;
      for (int k = 1; k < LaneLat; k++) vl_q[k] <= vl_q[k-1];
      out_valid_q <= vl_q[LaneLat-1];
    end
  end

  // Round to radians * 4096 and clamp
  function automatic logic signed [16:0] to_out(input logic signed [ZW+1:0] z,
                                                input int lo, input int hi);
    logic signed [ZW+2:0] r;
    logic signed [ZW+2:0] v;
    r = {z[ZW+1], z} + 22'sd8;
    v = r >>> 4;
    if (v < (ZW+3)'(lo)) v = (ZW+3)'(lo);
    if (v > (ZW+3)'(hi)) v = (ZW+3)'(hi);
    return v[16:0];
  endfunction

  // Output stage: combine lane angles by sign
  tlik_flag_t            fe;
  logic signed [ZW:0]    ze_x, za_x, zs_x, elb, ta, ts;
  logic signed [ZW+1:0]  sh;
  logic signed [16:0]    sh_o, el_o;
  assign fe   = fl_q[LaneLat-1];
  assign ze_x = {ze[ZW-1], ze};
  assign za_x = {za[ZW-1], za};
  assign zs_x = {zs[ZW-1], zs};

  always_comb begin
    elb = fe.neg ? (PiQ16 - ze_x) : ze_x;
    if (fe.x_zero) begin
      if (fe.y_zero)     ta = '0;
      else if (fe.y_neg) ta = -{HalfPiQ16[ZW-1], HalfPiQ16};
      else               ta = {HalfPiQ16[ZW-1], HalfPiQ16};
    end else begin
      ta = fe.a_flip ? -za_x : za_x;
    end
    if (fe.q2_zero) begin
      ts = fe.p2_zero ? '0 : {HalfPiQ16[ZW-1], HalfPiQ16};
    end else begin
      ts = fe.q2_neg ? -zs_x : zs_x;
    end
    sh   = {ta[ZW], ta} - {ts[ZW], ts};
    sh_o = to_out(sh, -OutPi, OutPi);
    el_o = to_out({elb[ZW], elb}, 0, OutPi);
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fe.unreach) begin
        shoulder_angle_o <= '0;
        elbow_angle_o    <= '0;
        unreachable_o    <= 1'b1;
      end else begin
        shoulder_angle_o <= sh_o[ShW-1:0];
        elbow_angle_o    <= el_o[ElW-1:0];
        unreachable_o    <= 1'b0;
      end
    end
  end

endmodule
